@@ src/lfv_pkg.sv @@
// ----------------------------------------------------------------------------
// lfv_pkg
// Shared types, constants and the TLV check function of the LLTD frame
// TLV validator.
// ----------------------------------------------------------------------------
package lfv_pkg;

    // Header layout.
    localparam logic [4:0] HDR_LEN         = 5'd4;
    localparam logic [4:0] BASE_LEN        = 5'd14;
    localparam logic [4:0] DISC_FIXED_LEN  = 5'd4;
    localparam logic [4:0] HELLO_FIXED_LEN = 5'd14;
    localparam logic [4:0] POS_VERSION     = 5'd0;
    localparam logic [4:0] POS_SERVICE     = 5'd1;
    localparam logic [4:0] POS_FUNCTION    = 5'd3;

    // Header field values.
    localparam logic [7:0] HDR_VERSION     = 8'h01;
    localparam logic [7:0] SVC_DISCOVERY_MAX = 8'h01;
    localparam logic [7:0] SVC_QUICK       = 8'h02;
    localparam logic [7:0] FN_DISCOVER     = 8'h00;
    localparam logic [7:0] FN_HELLO        = 8'h01;
    localparam logic [7:0] FN_KNOWN_MAX    = 8'h0c;
    localparam logic [7:0] TLV_IPV4        = 8'h07;
    localparam logic [7:0] IPV4_LEN        = 8'd4;

    // Frame status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SHORT       = 3'd1;
    localparam logic [2:0] ST_BAD_VERSION = 3'd2;
    localparam logic [2:0] ST_BAD_SERVICE = 3'd3;
    localparam logic [2:0] ST_BAD_FUNC    = 3'd4;
    localparam logic [2:0] ST_STATIONS    = 3'd5;
    localparam logic [2:0] ST_TLV_OVERRUN = 3'd6;

    // Report kinds.
    localparam logic KIND_TLV    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Configuration register indexes.
    localparam logic REG_HOST_ID_LENGTH = 1'b0;

    // Result queue depth.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_BASE     = 3'd1,
        PH_FIXED    = 3'd2,
        PH_STATIONS = 3'd3,
        PH_TLV_TYPE = 3'd4,
        PH_TLV_LEN  = 3'd5,
        PH_TLV_BODY = 3'd6,
        PH_SKIP     = 3'd7
    } t_lfv_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_lfv_in;

    typedef struct packed {
        logic        report_kind;
        logic [7:0]  tlv_type;
        logic [7:0]  tlv_length;
        logic        type_known;
        logic        length_ok;
        logic [31:0] ipv4_value;
        logic [2:0]  frame_status;
        logic [7:0]  service_type;
        logic [7:0]  function_code;
        logic        end_of_run;
    } t_lfv_out;

    // Up to two results written into the result queue in one cycle.
    typedef struct packed {
        logic [1:0] count;
        t_lfv_out   res0;
        t_lfv_out   res1;
    } t_lfv_push;

    // True when an 8-bit value is a multiple of six: even, and the sum of
    // its base-4 digits is a multiple of three.
    function automatic logic mult_of_six(input logic [7:0] l);
        logic [3:0] s;
        s = {2'b00, l[1:0]} + {2'b00, l[3:2]} + {2'b00, l[5:4]} + {2'b00, l[7:6]};
        return !l[0] && (s == 4'd0 || s == 4'd3 || s == 4'd6 || s == 4'd9 ||
                         s == 4'd12);
    endfunction

    // Bit 1: type known, bit 0: length meets the rule for the type.
    function automatic logic [1:0] check_tlv(input logic [7:0] t,
                                             input logic [7:0] l,
                                             input logic [4:0] host_len);
        logic ok;
        logic known;
        ok    = 1'b0;
        known = 1'b1;
        case (t)
            8'h00, 8'h11: ok = 1'b1;
            8'h01: ok = (l == {3'b000, host_len});
            8'h02, 8'h09, 8'h19: ok = (l == 8'd2);
            8'h03, 8'h07, 8'h0c, 8'h0d, 8'h14: ok = (l == 8'd4);
            8'h04, 8'h15: ok = (l == 8'd1);
            8'h05: ok = (l == 8'd6);
            8'h06: ok = (l <= 8'd32);
            8'h08, 8'h12: ok = (l == 8'd16);
            8'h0a: ok = (l == 8'd8);
            8'h0e, 8'h13, 8'h16, 8'h18, 8'h1a, 8'h1c: ok = (l == 8'd0);
            8'h0f: ok = (l >= 8'd2) && (l <= 8'd32);
            8'h10: ok = (l >= 8'd1) && (l <= 8'd64);
            8'h1b: ok = mult_of_six(l);
            default: known = 1'b0;
        endcase
        return {known, ok};
    endfunction

endpackage

@@ src/lfv_parser.sv @@
// ----------------------------------------------------------------------------
// lfv_parser
// Input register and frame parser: while the result queue has room, one byte
// per cycle updates the parse state and emits up to two results toward the queue.
// ----------------------------------------------------------------------------
module lfv_parser
    import lfv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_lfv_in   i_in_data,
    input  logic [4:0] i_host_id_length,
    input  logic      i_space_ok,
    output t_lfv_push o_push
);

    // Input register.
    logic    r_valid;
    t_lfv_in r_in;

    // Parse state.
    t_lfv_phase  r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic [7:0]  r_version, n_version;
    logic [7:0]  r_service, n_service;
    logic [7:0]  r_function, n_function;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_length, n_length;
    logic [7:0]  r_remain, n_remain;
    logic [2:0]  r_mod6, n_mod6;
    logic [31:0] r_addr, n_addr;
    logic [2:0]  r_err, n_err;

    logic       fire;
    logic       tlv_fire;
    logic [4:0] pos_inc;
    logic [4:0] need;
    logic [2:0] end_status;
    logic [1:0] chk;
    t_lfv_out   tlv_res;
    t_lfv_out   st_res;

    assign fire       = r_valid && i_space_ok;
    assign o_in_ready = !r_valid || i_space_ok;

    // Input register takes a new byte whenever the current one moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Next parse state for the registered byte.
    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_version  = r_version;
        n_service  = r_service;
        n_function = r_function;
        n_type     = r_type;
        n_length   = r_length;
        n_remain   = r_remain;
        n_mod6     = r_mod6;
        n_addr     = r_addr;
        n_err      = r_err;
        tlv_fire   = 1'b0;
        pos_inc    = r_pos + 5'd1;
        need       = (r_function == FN_DISCOVER) ? DISC_FIXED_LEN : HELLO_FIXED_LEN;

        case (r_phase)
            PH_HEADER: begin
                if (r_pos == POS_VERSION) n_version = r_in.data_byte;
                if (r_pos == POS_SERVICE) n_service = r_in.data_byte;
                if (r_pos == POS_FUNCTION) n_function = r_in.data_byte;
                n_pos = pos_inc;
                if (pos_inc >= HDR_LEN) begin
                    n_pos = '0;
                    if (n_version != HDR_VERSION) begin
                        n_err   = ST_BAD_VERSION;
                        n_phase = PH_SKIP;
                    end else if (n_service <= SVC_DISCOVERY_MAX) begin
                        n_phase = PH_BASE;
                    end else if (n_service == SVC_QUICK) begin
                        n_err   = ST_OK;
                        n_phase = PH_SKIP;
                    end else begin
                        n_err   = ST_BAD_SERVICE;
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_BASE: begin
                n_pos = pos_inc;
                if (pos_inc >= BASE_LEN) begin
                    n_pos = '0;
                    if (r_function <= FN_HELLO) begin
                        n_phase = PH_FIXED;
                    end else if (r_function <= FN_KNOWN_MAX) begin
                        n_err   = ST_OK;
                        n_phase = PH_SKIP;
                    end else begin
                        n_err   = ST_BAD_FUNC;
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_FIXED: begin
                n_pos = pos_inc;
                if (pos_inc >= need) begin
                    n_pos   = '0;
                    n_mod6  = '0;
                    n_phase = (r_function == FN_DISCOVER) ? PH_STATIONS : PH_TLV_TYPE;
                end
            end
            PH_STATIONS: begin
                n_mod6 = (r_mod6 >= 3'd5) ? 3'd0 : r_mod6 + 3'd1;
            end
            PH_TLV_TYPE: begin
                n_type  = r_in.data_byte;
                n_addr  = '0;
                n_phase = PH_TLV_LEN;
            end
            PH_TLV_LEN: begin
                n_length = r_in.data_byte;
                n_remain = r_in.data_byte;
                if (r_in.data_byte == 8'd0) begin
                    tlv_fire = 1'b1;
                    n_phase  = PH_TLV_TYPE;
                end else begin
                    n_phase = PH_TLV_BODY;
                end
            end
            PH_TLV_BODY: begin
                if (r_type == TLV_IPV4) n_addr = {r_addr[23:0], r_in.data_byte};
                if (r_remain != 8'd0) n_remain = r_remain - 8'd1;
                if (n_remain == 8'd0) begin
                    tlv_fire = 1'b1;
                    n_phase  = PH_TLV_TYPE;
                end
            end
            default: begin
            end
        endcase
    end

    // Frame status from the state left after this byte.
    always_comb begin
        case (n_phase)
            PH_STATIONS: end_status = (n_mod6 != 3'd0) ? ST_STATIONS : ST_OK;
            PH_TLV_TYPE, PH_TLV_LEN: end_status = ST_OK;
            PH_TLV_BODY: end_status = ST_TLV_OVERRUN;
            PH_SKIP: end_status = n_err;
            default: end_status = ST_SHORT;
        endcase
    end

    // Build the two possible results.
    assign chk = check_tlv(n_type, n_length, i_host_id_length);

    always_comb begin
        tlv_res               = '0;
        tlv_res.report_kind   = KIND_TLV;
        tlv_res.tlv_type      = n_type;
        tlv_res.tlv_length    = n_length;
        tlv_res.type_known    = chk[1];
        tlv_res.length_ok     = chk[0];
        tlv_res.ipv4_value    = (n_type == TLV_IPV4 && n_length == IPV4_LEN) ? n_addr : '0;
        tlv_res.frame_status  = ST_OK;
        tlv_res.service_type  = n_service;
        tlv_res.function_code = n_function;
        tlv_res.end_of_run    = !r_in.last_byte;

        st_res               = '0;
        st_res.report_kind   = KIND_STATUS;
        st_res.frame_status  = end_status;
        st_res.service_type  = n_service;
        st_res.function_code = n_function;
        st_res.end_of_run    = 1'b1;
    end

    // Queue write: the TLV report comes before the status report.
    always_comb begin
        o_push = '0;
        if (fire) begin
            o_push.count = {1'b0, tlv_fire} + {1'b0, r_in.last_byte};
            o_push.res0  = tlv_fire ? tlv_res : st_res;
            o_push.res1  = st_res;
        end
    end

    // Parse state register; the final byte returns it to the reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_in.last_byte)) begin
            r_phase    <= PH_HEADER;
            r_pos      <= '0;
            r_version  <= '0;
            r_service  <= '0;
            r_function <= '0;
            r_type     <= '0;
            r_length   <= '0;
            r_remain   <= '0;
            r_mod6     <= '0;
            r_addr     <= '0;
            r_err      <= ST_OK;
        end else if (fire) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_version  <= n_version;
            r_service  <= n_service;
            r_function <= n_function;
            r_type     <= n_type;
            r_length   <= n_length;
            r_remain   <= n_remain;
            r_mod6     <= n_mod6;
            r_addr     <= n_addr;
            r_err      <= n_err;
        end
    end

endmodule

@@ src/lfv_out_fifo.sv @@
// ----------------------------------------------------------------------------
// lfv_out_fifo
// Result queue that takes up to two results per cycle and hands out one
// result per output transfer.
// ----------------------------------------------------------------------------
module lfv_out_fifo
    import lfv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lfv_push i_push,
    output logic      o_space_ok,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_lfv_out  o_out_data
);

    t_lfv_out r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               pop;
    logic [FIFO_AW-1:0] wr_ptr1;

    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rd_ptr];
    assign pop         = o_out_valid && i_out_ready;
    assign wr_ptr1     = r_wr_ptr + 1'b1;

    // Room for two results, without counting a transfer in the same cycle.
    assign o_space_ok = (r_count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));

    // Pointer and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(i_push.count);
            if (pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (FIFO_AW + 1)'(i_push.count) -
                       (FIFO_AW + 1)'(pop);
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_mem[r_wr_ptr] <= i_push.res0;
        if (i_push.count == 2'd2) r_mem[wr_ptr1] <= i_push.res1;
    end

endmodule

@@ src/lltd_frame_tlv_validator.sv @@
// ----------------------------------------------------------------------------
// lltd_frame_tlv_validator
// LLTD payload parser that reports each completed TLV and the status of
// every frame.
// ----------------------------------------------------------------------------
// The block takes one payload byte per cycle on the input channel, with a
// flag on the final byte of the frame. Each byte is held in the input
// register while the parse logic works on it, and its results are written
// into the result queue that drives the output. A byte yields no
// result, a TLV report, a frame status report, or both (TLV first), and a
// four-entry result queue absorbs them, so bytes are taken at one per
// cycle while the output side keeps up; the input stalls only when the
// queue holds more than two results. HostID length sits at byte address 0
// of the register port and is to be written only while no frame is in
// flight.
// ----------------------------------------------------------------------------
module lltd_frame_tlv_validator
    import lfv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_lfv_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_lfv_out    o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0] r_host_id_length;
    logic       reg_sel;
    logic       space_ok;
    t_lfv_push  push;

    // Register port.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_HOST_ID_LENGTH);
    assign prdata  = reg_sel ? {27'd0, r_host_id_length} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_id_length <= 5'd6;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_host_id_length <= pwdata[4:0];
        end
    end

    lfv_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_data       (i_in_data),
        .i_host_id_length(r_host_id_length),
        .i_space_ok      (space_ok),
        .o_push          (push)
    );

    lfv_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule

@@ verif/lltd_frame_tlv_validator_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lltd_frame_tlv_validator_checker
// Watches the byte and report channels of the LLTD frame TLV validator, keeps
// its own copy of the frame parser, and compares every report it sees against
// the oldest report that the parser predicts.
// ----------------------------------------------------------------------------
module lltd_frame_tlv_validator_checker
    import lfv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_lfv_in     i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_lfv_out    i_out_data,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_mismatch_count,
    output int          o_pending
);

    localparam logic [4:0] HOST_ID_LENGTH_RESET = 5'd6;

    // TLV type codes.
    localparam logic [7:0] TLV_END_OF_PROPERTIES = 8'h00;
    localparam logic [7:0] TLV_HOST_ID           = 8'h01;
    localparam logic [7:0] TLV_CHARACTERISTICS   = 8'h02;
    localparam logic [7:0] TLV_PHY_MEDIUM        = 8'h03;
    localparam logic [7:0] TLV_WIRELESS_MODE     = 8'h04;
    localparam logic [7:0] TLV_BSSID             = 8'h05;
    localparam logic [7:0] TLV_SSID              = 8'h06;
    localparam logic [7:0] TLV_IPV6              = 8'h08;
    localparam logic [7:0] TLV_MAX_RATE          = 8'h09;
    localparam logic [7:0] TLV_PERF_CNT_FREQ     = 8'h0a;
    localparam logic [7:0] TLV_LINK_SPEED        = 8'h0c;
    localparam logic [7:0] TLV_RSSI              = 8'h0d;
    localparam logic [7:0] TLV_ICON              = 8'h0e;
    localparam logic [7:0] TLV_MACHINE_NAME      = 8'h0f;
    localparam logic [7:0] TLV_SUPPORT_INFO      = 8'h10;
    localparam logic [7:0] TLV_FRIENDLY_NAME     = 8'h11;
    localparam logic [7:0] TLV_UUID              = 8'h12;
    localparam logic [7:0] TLV_HARDWARE_ID       = 8'h13;
    localparam logic [7:0] TLV_QOS_CHARS         = 8'h14;
    localparam logic [7:0] TLV_WIFI_PHY_MEDIUM   = 8'h15;
    localparam logic [7:0] TLV_AP_TABLE          = 8'h16;
    localparam logic [7:0] TLV_DETAIL_ICON       = 8'h18;
    localparam logic [7:0] TLV_SEES_LIST         = 8'h19;
    localparam logic [7:0] TLV_COMPONENTS        = 8'h1a;
    localparam logic [7:0] TLV_REPEATER_LINEAGE  = 8'h1b;
    localparam logic [7:0] TLV_REPEATER_AP_TABLE = 8'h1c;

    // Parser state of the frame in flight.
    t_lfv_phase  phase;
    logic [4:0]  pos;
    logic [7:0]  version_seen;
    logic [7:0]  service_seen;
    logic [7:0]  function_seen;
    logic [7:0]  tlv_kind;
    logic [7:0]  tlv_len;
    logic [7:0]  body_left;
    logic [2:0]  station_mod6;
    logic [31:0] ipv4_acc;
    logic [2:0]  error_seen;
    logic [4:0]  host_len;

    t_lfv_out awaited_reports[$];
    int       mismatch_total  = 0;
    int       reports_checked = 0;

    initial o_pending = 0;
    assign o_mismatch_count = mismatch_total;

    // Return the parser to the start of a frame.
    task automatic restart_frame();
        phase         = PH_HEADER;
        pos           = '0;
        version_seen  = '0;
        service_seen  = '0;
        function_seen = '0;
        tlv_kind      = '0;
        tlv_len       = '0;
        body_left     = '0;
        station_mod6  = '0;
        ipv4_acc      = '0;
        error_seen    = ST_OK;
    endtask

    // Bit 1 says the type is recognized, bit 0 that the length fits its rule.
    function automatic logic [1:0] tlv_verdict(input logic [7:0] kind,
                                               input logic [7:0] len);
        logic fits;
        fits = 1'b0;
        case (kind)
            TLV_END_OF_PROPERTIES, TLV_FRIENDLY_NAME: fits = 1'b1;
            TLV_HOST_ID: fits = (len == {3'b000, host_len});
            TLV_CHARACTERISTICS, TLV_MAX_RATE, TLV_SEES_LIST: fits = (len == 8'd2);
            TLV_PHY_MEDIUM, TLV_IPV4, TLV_LINK_SPEED, TLV_RSSI, TLV_QOS_CHARS:
                fits = (len == 8'd4);
            TLV_WIRELESS_MODE, TLV_WIFI_PHY_MEDIUM: fits = (len == 8'd1);
            TLV_BSSID: fits = (len == 8'd6);
            TLV_SSID: fits = (len <= 8'd32);
            TLV_IPV6, TLV_UUID: fits = (len == 8'd16);
            TLV_PERF_CNT_FREQ: fits = (len == 8'd8);
            TLV_ICON, TLV_HARDWARE_ID, TLV_AP_TABLE, TLV_DETAIL_ICON, TLV_COMPONENTS,
            TLV_REPEATER_AP_TABLE: fits = (len == 8'd0);
            TLV_MACHINE_NAME: fits = (len >= 8'd2) && (len <= 8'd32);
            TLV_SUPPORT_INFO: fits = (len >= 8'd1) && (len <= 8'd64);
            TLV_REPEATER_LINEAGE: fits = ((len % 8'd6) == 8'd0);
            default: return 2'b00;
        endcase
        return {1'b1, fits};
    endfunction

    // Report for the TLV that has just been completed.
    function automatic t_lfv_out tlv_report();
        t_lfv_out r;
        r = '0;
        r.report_kind   = KIND_TLV;
        r.tlv_type      = tlv_kind;
        r.tlv_length    = tlv_len;
        {r.type_known, r.length_ok} = tlv_verdict(tlv_kind, tlv_len);
        r.ipv4_value    = (tlv_kind == TLV_IPV4 && tlv_len == IPV4_LEN) ? ipv4_acc : '0;
        r.frame_status  = ST_OK;
        r.service_type  = service_seen;
        r.function_code = function_seen;
        return r;
    endfunction

    // Advance the parser by one accepted byte and queue the reports it causes.
    task automatic parse_byte(input t_lfv_in item);
        t_lfv_out   made[$];
        t_lfv_out   status;
        t_lfv_out   r;
        logic [4:0] need;
        case (phase)
            PH_HEADER: begin
                if (pos == POS_VERSION) version_seen = item.data_byte;
                else if (pos == POS_SERVICE) service_seen = item.data_byte;
                else if (pos == POS_FUNCTION) function_seen = item.data_byte;
                pos = pos + 5'd1;
                if (pos >= HDR_LEN) begin
                    pos = '0;
                    if (version_seen != HDR_VERSION) begin
                        error_seen = ST_BAD_VERSION;
                        phase      = PH_SKIP;
                    end else if (service_seen <= SVC_DISCOVERY_MAX) begin
                        phase = PH_BASE;
                    end else if (service_seen == SVC_QUICK) begin
                        error_seen = ST_OK;
                        phase      = PH_SKIP;
                    end else begin
                        error_seen = ST_BAD_SERVICE;
                        phase      = PH_SKIP;
                    end
                end
            end
            PH_BASE: begin
                pos = pos + 5'd1;
                if (pos >= BASE_LEN) begin
                    pos = '0;
                    if (function_seen <= FN_HELLO) begin
                        phase = PH_FIXED;
                    end else if (function_seen <= FN_KNOWN_MAX) begin
                        error_seen = ST_OK;
                        phase      = PH_SKIP;
                    end else begin
                        error_seen = ST_BAD_FUNC;
                        phase      = PH_SKIP;
                    end
                end
            end
            PH_FIXED: begin
                need = (function_seen == FN_DISCOVER) ? DISC_FIXED_LEN : HELLO_FIXED_LEN;
                pos  = pos + 5'd1;
                if (pos >= need) begin
                    pos          = '0;
                    station_mod6 = '0;
                    phase = (function_seen == FN_DISCOVER) ? PH_STATIONS : PH_TLV_TYPE;
                end
            end
            PH_STATIONS: begin
                station_mod6 = (station_mod6 >= 3'd5) ? 3'd0 : station_mod6 + 3'd1;
            end
            PH_TLV_TYPE: begin
                tlv_kind = item.data_byte;
                ipv4_acc = '0;
                phase    = PH_TLV_LEN;
            end
            PH_TLV_LEN: begin
                tlv_len   = item.data_byte;
                body_left = item.data_byte;
                if (item.data_byte == 8'd0) begin
                    made.push_back(tlv_report());
                    phase = PH_TLV_TYPE;
                end else begin
                    phase = PH_TLV_BODY;
                end
            end
            PH_TLV_BODY: begin
                if (tlv_kind == TLV_IPV4) ipv4_acc = {ipv4_acc[23:0], item.data_byte};
                if (body_left != 8'd0) body_left = body_left - 8'd1;
                if (body_left == 8'd0) begin
                    made.push_back(tlv_report());
                    phase = PH_TLV_TYPE;
                end
            end
            default: ;
        endcase

        // The final byte closes the frame with a status report.
        if (item.last_byte) begin
            status               = '0;
            status.report_kind   = KIND_STATUS;
            status.service_type  = service_seen;
            status.function_code = function_seen;
            case (phase)
                PH_STATIONS: begin
                    status.frame_status = (station_mod6 != 3'd0) ? ST_STATIONS : ST_OK;
                end
                PH_TLV_TYPE, PH_TLV_LEN: status.frame_status = ST_OK;
                PH_TLV_BODY: status.frame_status = ST_TLV_OVERRUN;
                PH_SKIP: status.frame_status = error_seen;
                default: status.frame_status = ST_SHORT;
            endcase
            made.push_back(status);
            restart_frame();
        end

        // Only the last report of a byte carries the end-of-run flag.
        for (int k = 0; k < made.size(); k++) begin
            r = made[k];
            r.end_of_run = (k == made.size() - 1);
            awaited_reports.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_total++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("report %0d field %s is %0h, predicted %0h",
                                      reports_checked, field, got, want));
        end
    endtask

    // Follow both channels and the register port on every rising edge.
    always @(posedge i_clk) begin : monitor
        t_lfv_out want;
        if (!i_rst_n) begin
            restart_frame();
            host_len = HOST_ID_LENGTH_RESET;
            awaited_reports.delete();
        end else begin
            // Result transfer: compare with the oldest predicted report.
            if (i_out_valid && i_out_ready) begin
                if (awaited_reports.size() == 0) begin
                    report_mismatch("report transfer while no report is predicted");
                end else begin
                    want = awaited_reports.pop_front();
                    compare_field("report_kind", i_out_data.report_kind, want.report_kind);
                    compare_field("tlv_type", i_out_data.tlv_type, want.tlv_type);
                    compare_field("tlv_length", i_out_data.tlv_length, want.tlv_length);
                    compare_field("type_known", i_out_data.type_known, want.type_known);
                    compare_field("length_ok", i_out_data.length_ok, want.length_ok);
                    compare_field("ipv4_value", i_out_data.ipv4_value, want.ipv4_value);
                    compare_field("frame_status", i_out_data.frame_status,
                                  want.frame_status);
                    compare_field("service_type", i_out_data.service_type,
                                  want.service_type);
                    compare_field("function_code", i_out_data.function_code,
                                  want.function_code);
                    compare_field("end_of_run", i_out_data.end_of_run, want.end_of_run);
                end
                reports_checked++;
            end

            // Register write completes in the access phase.
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[2] == REG_HOST_ID_LENGTH) begin
                host_len = i_pwdata[4:0];
            end

            // Byte transfer: run the parser.
            if (i_in_valid && i_in_ready) parse_byte(i_in_data);
        end
        o_pending <= awaited_reports.size();
    end

endmodule

@@ verif/lltd_frame_tlv_validator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lltd_frame_tlv_validator_tb
// Drives LLTD payload bytes into the frame TLV validator and gives the verdict.
// A few short directed frames come first, then phases of random frames, mostly
// well-formed Hello and Discover frames with random content and some broken or
// truncated ones, each phase under its own HostID length and idle pattern.
// The checker beside the block predicts and compares every report.
// ----------------------------------------------------------------------------
module lltd_frame_tlv_validator_tb;
    import lfv_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_BYTES    = 110;
    localparam int SETTLE_CYCLES  = 8;

    typedef enum int {
        SHAPE_HELLO,
        SHAPE_DISCOVER,
        SHAPE_QUICK,
        SHAPE_OTHER_FN,
        SHAPE_BAD_FN,
        SHAPE_BAD_SERVICE,
        SHAPE_BAD_VERSION,
        SHAPE_NOISE
    } t_frame_shape;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        in_valid = 1'b0;
    t_lfv_in     in_data  = '0;
    logic        in_ready;
    logic        out_valid;
    t_lfv_out    out_data;
    logic        out_ready = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    logic       hold_req      = 1'b0;
    logic       hold_off      = 1'b0;
    int         idle_cycles   = 0;
    int         bytes_sent    = 0;
    int         mismatch_count;
    int         pending_count;
    logic [7:0] frame_bytes[$];

    // Clock with a 4 ns period.
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    lltd_frame_tlv_validator i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    lltd_frame_tlv_validator_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_data      (out_data),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_mismatch_count(mismatch_count),
        .o_pending       (pending_count)
    );

    // Report side: random stalls, plus a held-off stretch on request.
    always @(posedge clk) begin
        out_ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
    end

    // Long hold-off of the report side, counted here.
    initial begin : receiver_hold
        @(posedge hold_req);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Fill frame_bytes with one frame; a crowded frame is a Hello frame full
    // of empty TLVs, so that every second byte of its TLV area yields a report.
    task automatic build_frame(input bit crowded);
        t_frame_shape shape;
        int           pick;
        int           len;
        int           cut;
        frame_bytes.delete();
        pick = $urandom_range(0, 99);
        if (crowded)        shape = SHAPE_HELLO;
        else if (pick < 50) shape = SHAPE_HELLO;
        else if (pick < 63) shape = SHAPE_DISCOVER;
        else if (pick < 70) shape = SHAPE_QUICK;
        else if (pick < 77) shape = SHAPE_OTHER_FN;
        else if (pick < 83) shape = SHAPE_BAD_FN;
        else if (pick < 88) shape = SHAPE_BAD_SERVICE;
        else if (pick < 93) shape = SHAPE_BAD_VERSION;
        else                shape = SHAPE_NOISE;

        if (shape == SHAPE_NOISE) begin
            repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end

        // Header: version, service type, reserved, function.
        frame_bytes.push_back((shape == SHAPE_BAD_VERSION) ?
                              8'($urandom_range(2, 256)) : HDR_VERSION);
        case (shape)
            SHAPE_QUICK:       frame_bytes.push_back(SVC_QUICK);
            SHAPE_BAD_SERVICE: frame_bytes.push_back(8'($urandom_range(3, 255)));
            SHAPE_BAD_VERSION: frame_bytes.push_back(8'($urandom_range(0, 255)));
            default:           frame_bytes.push_back(8'($urandom_range(0, 1)));
        endcase
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        case (shape)
            SHAPE_HELLO:    frame_bytes.push_back(FN_HELLO);
            SHAPE_DISCOVER: frame_bytes.push_back(FN_DISCOVER);
            SHAPE_OTHER_FN: frame_bytes.push_back(8'($urandom_range(2, FN_KNOWN_MAX)));
            SHAPE_BAD_FN:   frame_bytes.push_back(8'($urandom_range(FN_KNOWN_MAX + 1, 255)));
            default:        frame_bytes.push_back(8'($urandom_range(0, 255)));
        endcase

        // Base header for the discovery functions.
        if (shape inside {SHAPE_HELLO, SHAPE_DISCOVER, SHAPE_OTHER_FN, SHAPE_BAD_FN}) begin
            repeat (BASE_LEN) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end

        case (shape)
            SHAPE_HELLO: begin
                repeat (HELLO_FIXED_LEN) frame_bytes.push_back(8'($urandom_range(0, 255)));
                repeat (crowded ? 24 : $urandom_range(0, 6)) begin
                    pick = $urandom_range(0, 99);
                    if (crowded) begin
                        frame_bytes.push_back(8'($urandom_range(0, 8'h1d)));
                        len = 0;
                    end else if (pick < 10) begin
                        frame_bytes.push_back(TLV_IPV4);
                        len = IPV4_LEN;
                    end else begin
                        frame_bytes.push_back((pick < 80) ? 8'($urandom_range(0, 8'h1d)) :
                                                            8'($urandom_range(0, 255)));
                        pick = $urandom_range(0, 99);
                        if (pick < 62)      len = $urandom_range(0, 8);
                        else if (pick < 80) len = $urandom_range(9, 40);
                        else if (pick < 96) len = $urandom_range(60, 66);
                        else if (pick < 99) len = $urandom_range(0, 255);
                        else                len = 255;
                    end
                    frame_bytes.push_back(8'(len));
                    repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
                end
                // Sometimes a lone byte trails the last TLV.
                if (!crowded && $urandom_range(0, 9) == 0) begin
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            SHAPE_DISCOVER: begin
                len = DISC_FIXED_LEN + 6 * $urandom_range(0, 4);
                if ($urandom_range(0, 4) == 0) len = len + $urandom_range(1, 5);
                repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase

        // Some frames end early, anywhere in the header, body or a TLV.
        if (!crowded && $urandom_range(0, 99) < 15) begin
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        end
    endtask

    // Offer the bytes of frame_bytes one transfer at a time, with random idles.
    task automatic send_frame();
        t_lfv_in item;
        logic    ready_seen;
        for (int k = 0; k < frame_bytes.size(); k++) begin
            item.data_byte = frame_bytes[k];
            item.last_byte = (k == frame_bytes.size() - 1);
            while ($urandom_range(0, 99) < send_idle_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= item;
            // Ready is stable by the falling edge; the transfer is at the next rise.
            do begin
                @(negedge clk);
                ready_seen = in_ready;
                @(posedge clk);
            end while (!ready_seen);
        end
        bytes_sent += frame_bytes.size();
    endtask

    // Stop offering bytes, wait for every predicted report, then let the
    // pipeline empty of bytes that cause no report.
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One phase: set the HostID length while idle, then random frames.
    task automatic run_phase(input logic [4:0] host_len, input int send_pct,
                             input int stall);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_HOST_ID_LENGTH, 2'b00};
        pwdata  <= {27'd0, host_len};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        send_idle_pct = send_pct;
        stall_pct    <= stall;
        bytes_sent    = 0;
        while (bytes_sent < PHASE_BYTES) begin
            build_frame(1'b0);
            send_frame();
        end
    endtask

    initial begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames: a lone byte with a wrong version is still short,
        // bad version, bad service ending right at the header, quick service,
        // and a header cut short.
        frame_bytes = '{8'hff};
        send_frame();
        frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hff};
        send_frame();
        frame_bytes = '{HDR_VERSION, 8'hff, 8'h00, 8'h00};
        send_frame();
        frame_bytes = '{HDR_VERSION, SVC_QUICK, 8'h00, 8'hff, 8'h00};
        send_frame();
        frame_bytes = '{HDR_VERSION, 8'h00, 8'h55};
        send_frame();

        // Random phases under different HostID lengths and idle patterns.
        run_phase(5'd1, 0, 0);
        run_phase(5'd16, 78, 0);
        run_phase(5'($urandom_range(1, 16)), 0, 78);
        run_phase(5'($urandom_range(1, 16)), 10, 10);
        run_phase(5'd6, 0, 0);

        // Hold the report side off while a crowded frame keeps coming.
        hold_req <= 1'b1;
        build_frame(1'b1);
        send_frame();

        settle();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
